>>> src/lfsr_keystream_descrambler_macros.svh
// Assertion helpers shared by the descrambler RTL.
`ifndef LFSR_KEYSTREAM_DESCRAMBLER_MACROS_SVH
`define LFSR_KEYSTREAM_DESCRAMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKD_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("descrambler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("descrambler check failed");

`endif

>>> src/lkd_pkg.sv
package lkd_pkg;

  localparam int LFSR_W    = 12;
  localparam int KEY_BYTES = 16;
  localparam int KEY_BITS  = KEY_BYTES * 8;
  localparam int HALF_BITS = KEY_BITS / 2;

  localparam logic [LFSR_W:0]   CRC_POLY  = 13'h180F;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 12'h829;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 12'h001;

  // input item kinds
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  // CRC of a key that has only bit pos set; key bit i is stream bit i.
  function automatic logic [LFSR_W-1:0] crc_of_bit(int pos);
    logic [LFSR_W:0] rem;
    rem = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      rem = {rem[LFSR_W-1:0], (i == pos)};
      if (rem[LFSR_W]) begin
        rem = rem ^ CRC_POLY;
      end
    end
    return rem[LFSR_W-1:0];
  endfunction

  // Key bits of one half that feed CRC bit k (the CRC is linear in the key).
  function automatic logic [HALF_BITS-1:0] crc_mask(int half, int k);
    logic [HALF_BITS-1:0] m;
    logic [LFSR_W-1:0]    c;
    m = '0;
    for (int j = 0; j < HALF_BITS; j++) begin
      c    = crc_of_bit(half * HALF_BITS + j);
      m[j] = c[k];
    end
    return m;
  endfunction

  // Advance the Fibonacci LFSR by one byte worth of steps.
  function automatic logic [LFSR_W-1:0] lfsr_adv8(logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v;
    for (int i = 0; i < 8; i++) begin
      s = {s[LFSR_W-2:0], ^(s & LFSR_TAPS)};
    end
    return s;
  endfunction

endpackage

>>> src/lkd_key_crc.sv
// Key CRC kept as two registered partial remainders, one per key half.
module lkd_key_crc
  import lkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [HALF_BITS-1:0] cfg_wdata,
  output logic [LFSR_W-1:0]    key_crc
);

  logic [LFSR_W-1:0] crc_lo_r, crc_lo_nxt;
  logic [LFSR_W-1:0] crc_hi_r, crc_hi_nxt;
  logic [LFSR_W-1:0] part_lo, part_hi;

  for (genvar k = 0; k < LFSR_W; k++) begin : g_bit
    localparam logic [HALF_BITS-1:0] MASK_LO = crc_mask(0, k);
    localparam logic [HALF_BITS-1:0] MASK_HI = crc_mask(1, k);
    assign part_lo[k] = ^(cfg_wdata & MASK_LO);
    assign part_hi[k] = ^(cfg_wdata & MASK_HI);
  end

  always_comb begin
    crc_lo_nxt = crc_lo_r;
    crc_hi_nxt = crc_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  crc_lo_nxt = part_lo;
        CFG_KEY_HIGH: crc_hi_nxt = part_hi;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_lo_r <= '0;
      crc_hi_r <= '0;
    end else begin
      crc_lo_r <= crc_lo_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  assign key_crc = crc_lo_r ^ crc_hi_r;

endmodule

>>> src/lkd_core.sv
// Keystream state and registered result stage.
module lkd_core
  import lkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [7:0]        data_byte,
  input  logic [LFSR_W-1:0] key_crc,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic [LFSR_W-1:0] out_crc
);

  `include "lfsr_keystream_descrambler_macros.svh"

  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic [LFSR_W-1:0] out_crc_r, out_crc_nxt;
  logic              accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lfsr_nxt      = lfsr_r;
    out_byte_nxt  = out_byte_r;
    out_crc_nxt   = out_crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_crc_nxt   = key_crc;
      if (op == OP_RESTART) begin
        lfsr_nxt     = (key_crc == '0) ? LFSR_SEED : key_crc;
        out_byte_nxt = '0;
      end else begin
        lfsr_nxt     = lfsr_adv8(lfsr_r);
        out_byte_nxt = data_byte ^ lfsr_r[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_crc_r  <= out_crc_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_crc   = out_crc_r;

  `LKD_ASSERT_NOW(a_lfsr_nonzero, clk, rst_n, 1'b1, lfsr_r != '0)
  `LKD_ASSERT_NEXT(a_restart_zero_byte, clk, rst_n, accept && op == OP_RESTART, out_byte_r == '0)
  `LKD_ASSERT_NEXT(a_restart_seed, clk, rst_n, accept && op == OP_RESTART && key_crc != '0, lfsr_r == $past(key_crc))
  `LKD_ASSERT_NEXT(a_data_advance, clk, rst_n, accept && op == OP_DATA, lfsr_r == lfsr_adv8($past(lfsr_r)))

endmodule

>>> src/lfsr_keystream_descrambler.sv
// Channel   Direction  tdata (low bit up)                     tuser
// in_       slave      [7:0] data_byte                         [0] operation
// out_      master     [7:0] out_byte, [19:8] key_crc, pad     none
// cfg_      write      cfg_index 0 key_low, 1 key_high         none
//
// One transaction per cycle unless a held result stalls, one registered
// result each: byte XOR between keystream and result registers, 8-step LFSR
// advance back into the keystream register. The key CRC is folded into two
// 12-bit partial remainders when configured, adding nothing per transaction.
// Reset (rst_n low, synchronous) seeds the LFSR with 1 and clears the key CRC.
// A stalled result holds in the output register; a new transaction is taken
// in the same cycle the held result drains.
module lfsr_keystream_descrambler
  import lkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic [0:0]           in_tuser,   // [0] operation
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] out_byte, [19:8] key_crc, [23:20] zero
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [HALF_BITS-1:0] cfg_wdata
);

  logic [LFSR_W-1:0] key_crc;
  logic [7:0]        res_byte;
  logic [LFSR_W-1:0] res_crc;

  // Hold the key CRC; update on a configuration write.
  lkd_key_crc u_key_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_crc   (key_crc)
  );

  // Run the keystream and register each result.
  lkd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op        (in_tuser[0]),
    .data_byte (in_tdata),
    .key_crc   (key_crc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (res_byte),
    .out_crc   (res_crc)
  );

  // Pack the result fields, padding to whole bytes.
  assign out_tdata = {4'b0000, res_crc, res_byte};

endmodule

>>> tb/sv/lkd_checker.sv
// Watches the input, result and configuration ports of the descrambler,
// predicts every result and compares it with what the block delivers.
module lkd_checker
  import lkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [23:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [HALF_BITS-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [12:0] KEY_CRC_POLY = 13'h180F;
  localparam logic [11:0] KS_TAPS      = 12'h829;
  localparam int          PRINT_CAP    = 200;

  typedef struct packed {
    logic [7:0]  plain;
    logic [11:0] crc;
  } descrambled_t;

  descrambled_t    expected_q[$];
  descrambled_t    want;
  descrambled_t    fresh;
  logic [63:0]     key_lo;
  logic [63:0]     key_hi;
  logic [11:0]     keystream;

  task automatic note_mismatch(input string what, input logic [23:0] got,
                               input logic [23:0] exp_val);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] descrambler mismatch, %s: got 0x%0h, want 0x%0h",
               $time, what, got, exp_val);
    end
    fail_count++;
  endtask

  // CRC-12 over key bytes 0..15, bits of each byte LSB first, zero start.
  function automatic logic [11:0] key_crc_of(logic [63:0] lo, logic [63:0] hi);
    logic [127:0] key;
    logic [12:0]  rem;
    key = {hi, lo};
    rem = '0;
    for (int i = 0; i < 128; i++) begin
      rem = {rem[11:0], key[i]};
      if (rem[12]) begin
        rem = rem ^ KEY_CRC_POLY;
      end
    end
    return rem[11:0];
  endfunction

  // Eight Fibonacci steps: new bit enters at the bottom.
  function automatic logic [11:0] keystream_next_byte(logic [11:0] s);
    logic [11:0] v;
    v = s;
    for (int i = 0; i < 8; i++) begin
      v = {v[10:0], ^(v & KS_TAPS)};
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_lo    = '0;
      key_hi    = '0;
      keystream = LFSR_SEED;
      expected_q.delete();
    end else begin
      // Drain first: a result never leaves in the edge its item enters.
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          note_mismatch("result with nothing pending", out_tdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[7:0] !== want.plain) begin
            note_mismatch("out_byte", 24'(out_tdata[7:0]), 24'(want.plain));
          end
          if (out_tdata[19:8] !== want.crc) begin
            note_mismatch("key_crc", 24'(out_tdata[19:8]), 24'(want.crc));
          end
          if (out_tdata[23:20] !== 4'h0) begin
            note_mismatch("tdata pad", 24'(out_tdata[23:20]), '0);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh.crc = key_crc_of(key_lo, key_hi);
        if (in_tuser[0] == OP_RESTART) begin
          keystream   = (fresh.crc == '0) ? LFSR_SEED : fresh.crc;
          fresh.plain = '0;
        end else begin
          fresh.plain = in_tdata ^ keystream[7:0];
          keystream   = keystream_next_byte(keystream);
        end
        expected_q.push_back(fresh);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_LOW) begin
          key_lo = cfg_wdata;
        end else begin
          key_hi = cfg_wdata;
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus and verdict for the keystream descrambler; the checking lives in
// lkd_checker, which sits beside the block and reports a failure count.
module tb_top
  import lkd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Key whose bit stream equals the CRC polynomial itself: nonzero, CRC zero.
  localparam logic [63:0] ZERO_CRC_KEY_HIGH = 64'hF018_0000_0000_0000;
  localparam logic [63:0] ALL_ONES          = {64{1'b1}};
  localparam int          PHASES            = 8;
  localparam int          PHASE_ITEMS       = 250;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [HALF_BITS-1:0] cfg_wdata;
  int                   fail_count;
  int                   pending;

  // Sender pacing: burst length left, and whether gaps are allowed at all.
  int                   burst_left;
  bit                   gaps_on;
  int                   items_sent;

  // Receiver pattern state.
  int                   rx_cycle;
  int                   rx_mode;

  lfsr_keystream_descrambler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lkd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: pick random stall patterns in turn, from always-ready
  // to mostly stalled, so back-pressure lands on every phase of the stream.
  always @(negedge clk) begin
    if (rx_cycle % 128 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (rx_cycle % 5 == 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
    rx_cycle++;
  end

  // Hard stop if the stream ever hangs.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Drop valid for an idle gap whose length is set by n.
  task automatic idle_gap(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Present one transaction and hold it until the block takes it.
  task automatic send(input logic op, input logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        idle_gap($urandom_range(1, 6));
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do begin
      @(posedge clk);
    end while (!in_tready);
    items_sent++;
  endtask

  // Stop sending and wait until every pending result is out, plus margin.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both key halves; only called once the block is idle.
  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_KEY_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A well-formed frame: restart, then a run of data bytes.
  task automatic send_frame();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    send(OP_RESTART, 8'($urandom_range(0, 255)));
    for (int i = 0; i < len; i++) begin
      send(OP_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  // Noise: items of random kind, restarts landing anywhere.
  task automatic send_noise();
    int len;
    len = $urandom_range(1, 16);
    for (int i = 0; i < len; i++) begin
      send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    logic [63:0] lo;
    logic [63:0] hi;

    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_DATA;
    cfg_we     = 1'b0;
    cfg_index  = CFG_KEY_LOW;
    cfg_wdata  = '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    items_sent = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Data before any restart runs from the reset seed.
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'hFF);
    send(OP_DATA, 8'hA5);
    // Reset key has a zero CRC: restart must seed 1; restart ignores its data.
    send(OP_RESTART, 8'h5A);
    send(OP_DATA, 8'hFF);
    send(OP_DATA, 8'h00);

    load_key(ALL_ONES, ALL_ONES);
    send(OP_RESTART, 8'hFF);
    send(OP_DATA, 8'h00);
    send(OP_DATA, 8'hFF);

    // Nonzero key that still yields a zero CRC.
    load_key('0, ZERO_CRC_KEY_HIGH);
    send(OP_RESTART, 8'h00);
    send(OP_DATA, 8'h3C);

    load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send(OP_RESTART, 8'hC3);
    send(OP_DATA, 8'h80);

    // New key after a restart: keystream runs on, only the CRC moves.
    load_key(ALL_ONES, '0);
    send(OP_DATA, 8'h01);
    send(OP_DATA, 8'h7F);
    send(OP_RESTART, 8'h81);
    send(OP_DATA, 8'hFF);

    // Random phases, each under its own key.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          lo = '0;
          hi = '0;
        end
        2: begin
          lo = ALL_ONES;
          hi = ALL_ONES;
        end
        3: begin
          lo = '0;
          hi = ZERO_CRC_KEY_HIGH;
        end
        4: begin
          lo = '0;
          hi = ALL_ONES;
        end
        default: begin
          lo = rand64();
          hi = rand64();
        end
      endcase
      load_key(lo, hi);
      gaps_on = (ph % 3 != 2);
      target  = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          send_frame();
        end else begin
          send_noise();
        end
        // Occasionally hold off until the output side has caught up.
        if ($urandom_range(0, 19) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
